[rtl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    typedef enum logic [2:0] {
        FN_WRITE = 3'd0,
        FN_KEY   = 3'd1,
        FN_BKSP  = 3'd2,
        FN_ENDL  = 3'd3,
        FN_CLEAR = 3'd4,
        FN_READ  = 3'd5
    } t_func;

    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    localparam logic [7:0] ATTR_RESET  = 8'd15;
    localparam logic [6:0] LIMIT_RESET = 7'd40;

    // register index taken from paddr[2]
    localparam logic REG_ATTR  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef struct packed {
        logic [7:0] attr;
        logic [6:0] limit;
    } t_cfg;

endpackage

[rtl/tcw_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tcw_regs.sv]
// APB configuration registers: attribute and line limit.
`timescale 1ns / 1ps

module tcw_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [2:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    output logic [31:0]   o_prdata,
    output logic          o_pready,
    output tcw_pkg::t_cfg o_cfg
);

    logic [7:0] r_attr;
    logic [6:0] r_limit;
    logic       wr;

    assign o_pready = 1'b1;
    assign wr       = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr  <= tcw_pkg::ATTR_RESET;
            r_limit <= tcw_pkg::LIMIT_RESET;
        end else if (wr) begin
            if (i_paddr[2] == tcw_pkg::REG_ATTR) begin
                r_attr <= i_pwdata[7:0];
            end else begin
                r_limit <= i_pwdata[6:0];
            end
        end
    end

    always_comb begin
        if (i_paddr[2] == tcw_pkg::REG_LIMIT) begin
            o_prdata = {25'd0, r_limit};
        end else begin
            o_prdata = {24'd0, r_attr};
        end
    end

    assign o_cfg.attr  = r_attr;
    assign o_cfg.limit = r_limit;

endmodule

[rtl/tcw_seq.sv]
// Command sequencer: cursor, line length, cell updates, scroll and clear sweeps.
`timescale 1ns / 1ps

module tcw_seq #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25,
    localparam int CELLS = COLUMNS * ROWS,
    localparam int AW = $clog2(CELLS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tcw_pkg::t_cfg i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [2:0]    i_func,
    input  logic [7:0]    i_char,
    input  logic [10:0]   i_raddr,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [10:0]   o_cursor,
    output logic [15:0]   o_rdata,
    output logic          o_scrolled,
    output logic          o_accepted,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output logic [15:0]   o_mem_wdata,
    output logic [AW-1:0] o_mem_raddr,
    input  logic [15:0]   i_mem_rdata
);

    localparam int CW = $clog2(COLUMNS);
    localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
    localparam logic [AW-1:0] BOTTOM_A = AW'(COLUMNS * (ROWS - 1));
    localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
    localparam logic [AW-1:0] AHEAD_A  = AW'(COLUMNS + 1);
    localparam logic [CW-1:0] LCOL_C   = CW'(COLUMNS - 1);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_SWEEP = 6'b001000,
        S_RD    = 6'b010000,
        S_RDW   = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [2:0]    r_func;
    logic [7:0]    r_char;
    logic [10:0]   r_addr;
    logic [AW-1:0] r_cursor, n_cursor;
    logic [CW-1:0] r_col, n_col;
    logic [6:0]    r_len, n_len;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_scroll, n_scroll;
    logic          r_scrolled, n_scrolled;
    logic          r_acc, n_acc;
    logic          r_out_valid;
    logic [10:0]   r_o_cursor;
    logic [15:0]   r_o_data;
    logic          r_o_scr, r_o_acc;

    logic          key_ok, bs_ok, put, load;
    logic [7:0]    pch;
    logic [15:0]   blank;
    logic          addr_ok;

    assign blank   = {i_cfg.attr, tcw_pkg::CHAR_SPACE};
    assign key_ok  = (r_func == tcw_pkg::FN_KEY) && (r_len < i_cfg.limit);
    assign bs_ok   = (r_func == tcw_pkg::FN_BKSP) && (r_len != 7'd0);
    assign put     = (r_func == tcw_pkg::FN_WRITE) || key_ok || (r_func == tcw_pkg::FN_ENDL);
    assign pch     = (r_func == tcw_pkg::FN_ENDL) ? tcw_pkg::CHAR_NL : r_char;
    assign addr_ok = 32'(r_addr) < 32'(CELLS);
    assign load    = (r_state == S_RDW) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_col       = r_col;
        n_len       = r_len;
        n_idx       = r_idx;
        n_scroll    = r_scroll;
        n_scrolled  = r_scrolled;
        n_acc       = r_acc;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cursor;
        o_mem_wdata = blank;
        o_mem_raddr = AW'(r_addr);
        case (r_state)
            S_INIT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx;
                o_mem_wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::CHAR_SPACE};
                n_idx       = r_idx + 1'b1;
                if (r_idx == LAST_A) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state    = S_RD;
                n_scrolled = 1'b0;
                n_acc      = key_ok || bs_ok;
                n_idx      = '0;
                o_mem_raddr = COLS_A;
                if (key_ok && r_char != tcw_pkg::CHAR_NUL) begin
                    n_len = r_len + 1'b1;
                end
                if (r_func == tcw_pkg::FN_ENDL) begin
                    n_len = '0;
                end
                if (put && pch == tcw_pkg::CHAR_NL) begin
                    if (r_cursor >= BOTTOM_A) begin
                        n_scroll   = 1'b1;
                        n_scrolled = 1'b1;
                        n_cursor   = BOTTOM_A;
                        n_state    = S_SWEEP;
                    end else begin
                        n_cursor = r_cursor - AW'(r_col) + COLS_A;
                    end
                    n_col = '0;
                end else if (put && pch != tcw_pkg::CHAR_NUL) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_cursor;
                    o_mem_wdata = {i_cfg.attr, pch};
                    n_cursor    = (r_cursor == LAST_A) ? '0 : r_cursor + 1'b1;
                    n_col       = (r_col == LCOL_C) ? '0 : r_col + 1'b1;
                end else if (bs_ok) begin
                    n_len       = r_len - 1'b1;
                    n_cursor    = (r_cursor == '0) ? LAST_A : r_cursor - 1'b1;
                    n_col       = (r_col == '0) ? LCOL_C : r_col - 1'b1;
                    o_mem_we    = 1'b1;
                    o_mem_waddr = n_cursor;
                end else if (r_func == tcw_pkg::FN_CLEAR) begin
                    n_scroll = 1'b0;
                    n_cursor = '0;
                    n_col    = '0;
                    n_state  = S_SWEEP;
                end
            end
            S_SWEEP: begin
                // reads run one row ahead of the writes, so no overlap on an entry
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx;
                o_mem_wdata = (r_scroll && r_idx < BOTTOM_A) ? i_mem_rdata : blank;
                o_mem_raddr = r_idx + AHEAD_A;
                n_idx       = r_idx + 1'b1;
                if (r_idx == LAST_A) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_RDW;
            end
            S_RDW: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_cursor    <= '0;
            r_col       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_len       <= n_len;
            r_out_valid <= load || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_scroll   <= n_scroll;
        r_scrolled <= n_scrolled;
        r_acc      <= n_acc;
        if (r_state == S_IDLE && i_in_valid) begin
            r_func <= i_func;
            r_char <= i_char;
            r_addr <= i_raddr;
        end
        if (load) begin
            r_o_cursor <= 11'(r_cursor);
            r_o_data   <= addr_ok ? i_mem_rdata : 16'd0;
            r_o_scr    <= r_scrolled;
            r_o_acc    <= r_acc;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cursor    = r_o_cursor;
    assign o_rdata     = r_o_data;
    assign o_scrolled  = r_o_scr;
    assign o_accepted  = r_o_acc;

endmodule

[rtl/text_console_writer.sv]
// Top level of the text console writer.
`timescale 1ns / 1ps
// Text-mode console engine over a COLUMNS x ROWS cell store (char low byte,
// attribute high byte) held in one block RAM.
// Input beat (s_axis): tuser = function code, tdata = character and the cell
// address to report. Output beat (m_axis): cursor, cell content, scrolled and
// accepted flags; exactly one output beat per input beat, in order.
// Configuration: APB, attribute at 0x0, line limit at 0x4; pready is always
// high. Write registers only while no beat is in flight.
// Sequence: a plain function goes from input beat to output beat through accept,
// update, RAM read and capture; the next input beat can be taken the
// cycle after the result is captured. Scroll and clear sweep the RAM through
// its single write port, one cell per cycle, before the RAM read.
// Reset: the store is blanked by a sweep of all COLUMNS*ROWS cells with attribute
// 15; s_axis_tready stays low until it is done. APB writes are taken meanwhile.
// Stall: the result sits in an output register; a new beat is accepted while it
// waits, and that beat's work stalls at capture until the register frees up.

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [7:0] char_code, [18:8] read_address
    input  logic [2:0]  s_axis_tuser,  // [2:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [10:0] cursor, [26:11] read_data,
                                       // [27] scrolled, [28] accepted
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW = $clog2(CELLS);

    tcw_pkg::t_cfg cfg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata, mem_rdata;
    logic [10:0]   cursor;
    logic [15:0]   rdata;
    logic          scrolled, accepted;

    tcw_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_char      (s_axis_tdata[7:0]),
        .i_raddr     (s_axis_tdata[18:8]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cursor    (cursor),
        .o_rdata     (rdata),
        .o_scrolled  (scrolled),
        .o_accepted  (accepted),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    assign m_axis_tdata = {3'd0, accepted, scrolled, rdata, cursor};

endmodule

[rtl/tcw_chk.sv]
// Port-level checker for the text console writer, bound to the top level.
`timescale 1ns / 1ps

module tcw_chk #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam logic [10:0] BOTTOM = 11'(COLUMNS * (ROWS - 1));

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // the blanking sweep keeps the input closed right after reset
    a_init: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("block open right after reset");

    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[10:0]) < 32'(CELLS))
        else $error("cursor out of range");

    // a scroll always leaves the cursor at the start of the bottom row
    a_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[27] |-> m_axis_tdata[10:0] == BOTTOM)
        else $error("scroll left cursor off bottom row start");

endmodule

bind text_console_writer tcw_chk #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
